// File: rtl/core/gm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
`timescale 1ns / 1ps
package gm_pkg;

    // Longest pattern the cell row supports; the row has one more cell for the end position.
    localparam int PATTERN_MAX = 16;
    localparam int NUM_CELLS   = PATTERN_MAX + 1;

    // The pattern registers hold this many bytes; positions past them read as zero.
    localparam int PAT_REG_BYTES = 16;
    localparam int PAT_BITS      = 8 * PAT_REG_BYTES;
    localparam int LEN_W         = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW   = 2'd0,
        CFG_PAT_HIGH  = 2'd1,
        CFG_PAT_LEN   = 2'd2,
        CFG_PATH_MODE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PAT_BITS-1:0] pattern;
        logic [LEN_W-1:0]    length;
        logic                path_mode;
    } t_cfg;

    // Signals handed from one cell to its right-hand neighbor.
    typedef struct packed {
        logic in_use;  // this position lies inside the effective pattern
        logic close;   // active star here makes the next position active too
        logic fwd;     // this position consumes the current byte and advances
    } t_link;

endpackage

// File: rtl/core/gm_in_if.sv
// Input channel: one text byte per word, with an end-of-text flag.
`timescale 1ns / 1ps
interface gm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: rtl/core/gm_out_if.sv
// Output channel: one match verdict per word.
`timescale 1ns / 1ps
interface gm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// File: rtl/core/wildcard_glob_match.sv
// Top level of the wildcard glob matcher: config bank, cell row and output register.
`timescale 1ns / 1ps
// Streams a text, one byte per word on i_in, against a wildcard pattern of up to
// 16 bytes held in the configuration registers ('*' any run, '?' one byte).
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data:
// index 0 pattern bytes 0-7, 1 bytes 8-15, 2 pattern length, 3 path mode.
// A word with end_of_text set, or with a zero byte, closes the text; one word
// carrying the verdict appears on o_out in the cycle after it is accepted, and the
// matcher is back at the start of the pattern for the next text. Other words
// give no output.
// The row holds one cell per pattern position plus one for the end; every
// accepted word updates all cells at once, so one word is taken per cycle unless an end word is held back (below).
// The star closure ripples across the row within that cycle.
// A verdict waits in the output register while o_out is stalled; a new word is
// still taken in that case unless it would produce a second verdict.
// Reset clears the config registers and the output valid to zero and leaves only position zero active.
module wildcard_glob_match
    import gm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gm_in_if.sink                 i_in,
    gm_out_if.source              o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                 cfg;
    t_link                link [NUM_CELLS+1];
    logic [NUM_CELLS-1:0] active;
    logic [NUM_CELLS-1:0] closed;
    logic [NUM_CELLS-1:0] is_end;
    logic                 in_ready;
    logic                 accept;
    logic                 end_word;
    logic                 wild_ok;
    logic                 result;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_matched;

    gm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign end_word = i_in.end_of_text | (i_in.text_byte == CH_NUL);
    // An end word can only enter when the output register is free or draining.
    assign in_ready = ~r_out_valid | o_out.ready | ~end_word;
    assign accept   = i_in.valid & in_ready;
    assign wild_ok  = ~(cfg.path_mode &
                        ((i_in.text_byte == CH_SLASH) | (i_in.text_byte == CH_BSLASH)));

    assign link[0] = '{in_use: 1'b1, close: 1'b0, fwd: 1'b0};

    for (genvar p = 0; p < NUM_CELLS; p++) begin : g_cell
        logic [7:0] pat_byte;
        logic       pos_ok;

        if (p < PAT_REG_BYTES) begin : g_byte
            assign pat_byte = cfg.pattern[8*p +: 8];
        end else begin : g_nobyte
            assign pat_byte = CH_NUL;
        end

        assign pos_ok = (p < PATTERN_MAX) && (32'(p) < 32'(cfg.length));

        gm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_start_val ((p == 0) ? 1'b1 : 1'b0),
            .i_step      (accept & ~end_word),
            .i_restart   (accept & end_word),
            .i_pat_byte  (pat_byte),
            .i_pos_ok    (pos_ok),
            .i_wild_ok   (wild_ok),
            .i_text_byte (i_in.text_byte),
            .i_left      (link[p]),
            .o_right     (link[p+1]),
            .o_active    (active[p]),
            .o_closed    (closed[p]),
            .o_is_end    (is_end[p])
        );
    end

    // The match is the closed bit at the effective end of the pattern.
    assign result = |(closed & is_end);

    always_comb begin
        n_out_valid = r_out_valid & ~o_out.ready;
        if (accept & end_word) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept & end_word) begin
            r_matched <= result;
        end
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.matched = r_matched;

    a_end_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept & end_word) |=> o_out.valid)
        else $error("end word did not produce an output word");

    a_restart_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept & end_word) |=> (active == NUM_CELLS'(1)))
        else $error("active set not back at position zero after end word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (~r_out_valid & ~(accept & end_word)) |=> ~o_out.valid)
        else $error("output word without an end word");

    a_one_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(is_end))
        else $error("pattern end position is not unique");

endmodule

// File: rtl/core/gm_cfg.sv
// Configuration register bank for the glob matcher.
`timescale 1ns / 1ps
module gm_cfg
    import gm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [LEN_W-1:0]      r_length;
    logic                  r_path_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_length    <= '0;
            r_path_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LOW:   r_pat_low   <= i_cfg_data;
                CFG_PAT_HIGH:  r_pat_high  <= i_cfg_data;
                CFG_PAT_LEN:   r_length    <= i_cfg_data[LEN_W-1:0];
                CFG_PATH_MODE: r_path_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.pattern   = {r_pat_high, r_pat_low};
    assign o_cfg.length    = r_length;
    assign o_cfg.path_mode = r_path_mode;

endmodule

// File: rtl/core/gm_cell.sv
// One pattern position of the matcher row: its active bit and its step logic.
`timescale 1ns / 1ps
module gm_cell
    import gm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start_val,
    input  logic       i_step,
    input  logic       i_restart,
    input  logic [7:0] i_pat_byte,
    input  logic       i_pos_ok,
    input  logic       i_wild_ok,
    input  logic [7:0] i_text_byte,
    input  t_link      i_left,
    output t_link      o_right,
    output logic       o_active,
    output logic       o_closed,
    output logic       o_is_end
);

    logic r_act;
    logic n_act;
    logic in_use;
    logic closed;
    logic live;
    logic is_star;
    logic is_quest;

    assign is_star  = (i_pat_byte == CH_STAR);
    assign is_quest = (i_pat_byte == CH_QUEST);

    // A zero byte ends the pattern, so use stops at the first one.
    assign in_use   = i_left.in_use & i_pos_ok & (i_pat_byte != CH_NUL);
    assign o_is_end = i_left.in_use & ~in_use;

    // Closure over stars ripples in from the left like a carry.
    assign closed = r_act | i_left.close;
    assign live   = closed & in_use;

    assign o_right.in_use = in_use;
    assign o_right.close  = live & is_star;
    assign o_right.fwd    = live & ((is_quest & i_wild_ok) |
                                    (~is_star & ~is_quest & (i_pat_byte == i_text_byte)));

    always_comb begin
        n_act = r_act;
        if (i_restart) begin
            n_act = i_start_val;
        end else if (i_step) begin
            n_act = (live & is_star & i_wild_ok) | i_left.fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_start_val;
        end else begin
            r_act <= n_act;
        end
    end

    assign o_active = r_act;
    assign o_closed = closed;

endmodule
